### hdl/ast_pkg.sv
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and constants of the attribute span tokenizer.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int unsigned POS_WIDTH   = 16;
  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned MAX_EVENTS  = 4;
  localparam int unsigned EV_IDX_W    = $clog2(MAX_EVENTS);
  localparam int unsigned CNT_W       = $clog2(MAX_EVENTS + 1);
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic EV_DIRTY = 1'b0;
  localparam logic EV_ATTR  = 1'b1;

  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
  localparam logic [1:0] QUOTE_SINGLE = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] eq_len;
    logic [FIELD_W-1:0] val_len;
    logic [1:0]         quote_kind;
    logic               quote_closed;
  } event_t;

  typedef struct packed {
    event_t [MAX_EVENTS-1:0] ev;
    logic [CNT_W-1:0]        count;
    logic                    ovf;
    logic                    eor;
  } bundle_t;

endpackage

### hdl/ast_intf.sv
// ----------------------------------------------------------------------------
// ast_intf
// Byte and event channels of the attribute span tokenizer.
// ----------------------------------------------------------------------------
interface ast_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface ast_event_if;
  logic        valid;
  logic        ready;
  logic        event_kind;
  logic [15:0] span_start;
  logic [15:0] span_len;
  logic [15:0] eq_run_len;
  logic [15:0] value_len;
  logic [1:0]  quote_kind;
  logic        quote_closed;
  logic        length_overflow;
  logic        end_of_record;

  modport source (
    output valid, output event_kind, output span_start, output span_len,
    output eq_run_len, output value_len, output quote_kind, output quote_closed,
    output length_overflow, output end_of_record, input ready
  );
  modport sink (
    input valid, input event_kind, input span_start, input span_len,
    input eq_run_len, input value_len, input quote_kind, input quote_closed,
    input length_overflow, input end_of_record, output ready
  );
endinterface

### hdl/attribute_span_tokenizer.sv
// ----------------------------------------------------------------------------
// attribute_span_tokenizer
// Scans attribute bytes and reports attribute and dirty spans as event items.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue is not full; a byte that
//   closes spans yields up to four event items, held in a four-bundle queue
//   and sent one per cycle from the output register while the output is ready.
// Reset: scanner returns between attributes with all positions zero, queue
//   and output register empty.
// ----------------------------------------------------------------------------
module attribute_span_tokenizer #(
  parameter int unsigned POS_WIDTH = ast_pkg::POS_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ast_byte_if.sink    byte_i,
  ast_event_if.source event_o
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  ast_pkg::bundle_t q_in;
  ast_pkg::bundle_t q_head;

  ast_front #(
    .POS_WIDTH(POS_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .full_i  (q_full),
    .push_o  (q_push),
    .bundle_o(q_in)
  );

  ast_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head),
    .empty_o(q_empty)
  );

  ast_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (q_head),
    .empty_i(q_empty),
    .pop_o  (q_pop),
    .event_o(event_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("bundle pushed into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_empty && (!event_o.valid || event_o.ready)) |=> event_o.valid)
    else $error("pending bundle not moved to output");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_o.valid && event_o.event_kind == ast_pkg::EV_DIRTY) |->
      (event_o.eq_run_len == '0 && event_o.value_len == '0 &&
       event_o.quote_kind == ast_pkg::QUOTE_NONE && !event_o.quote_closed))
    else $error("dirty item carries attribute fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (event_o.valid && event_o.quote_closed) |-> (event_o.quote_kind != ast_pkg::QUOTE_NONE))
    else $error("closed quote without quote kind");

endmodule

### hdl/ast_front.sv
// ----------------------------------------------------------------------------
// ast_front
// Accepts bytes, runs the span scanner and builds one event bundle per byte.
// ----------------------------------------------------------------------------
module ast_front #(
  parameter int unsigned POS_WIDTH = ast_pkg::POS_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ast_byte_if.sink         byte_i,
  input  logic             full_i,
  output logic             push_o,
  output ast_pkg::bundle_t bundle_o
);

  typedef enum logic [5:0] {
    MODE_BETWEEN = 6'b000001,
    MODE_KEY     = 6'b000010,
    MODE_GAP     = 6'b000100,
    MODE_EQWS    = 6'b001000,
    MODE_VALU    = 6'b010000,
    MODE_VALQ    = 6'b100000
  } mode_e;

  typedef logic [POS_WIDTH-1:0] pos_t;

  localparam pos_t POS_MAX  = '1;
  localparam pos_t POS_ZERO = '0;
  localparam pos_t POS_ONE  = pos_t'(1);

  localparam logic [1:0] QUOTE_NONE   = ast_pkg::QUOTE_NONE;
  localparam logic [1:0] QUOTE_DOUBLE = ast_pkg::QUOTE_DOUBLE;
  localparam logic [1:0] QUOTE_SINGLE = ast_pkg::QUOTE_SINGLE;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;

  function automatic logic is_ws(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF || c == CH_VT;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic first_ok(input logic [7:0] c);
    return is_alpha(c) || c == CH_US || c == CH_COLON;
  endfunction

  function automatic logic rest_ok(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_COLON || c == CH_DOT ||
           c == CH_US || c == CH_DASH;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return c == CH_SLASH || c == CH_EQ || is_ws(c);
  endfunction

  function automatic pos_t sat_inc(input pos_t x);
    return (x == POS_MAX) ? x : x + POS_ONE;
  endfunction

  function automatic pos_t sat_add(input pos_t a, input pos_t b);
    logic [POS_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[POS_WIDTH] ? POS_MAX : s[POS_WIDTH-1:0];
  endfunction

  function automatic pos_t sat_sub(input pos_t a, input pos_t b);
    return (a >= b) ? a - b : POS_ZERO;
  endfunction

  function automatic ast_pkg::event_t mk_ev(input logic kind, input pos_t start, input pos_t len,
                                            input pos_t eq, input pos_t val,
                                            input logic [1:0] qk, input logic qc);
    ast_pkg::event_t e;
    e.kind         = kind;
    e.start        = ast_pkg::FIELD_W'(start);
    e.len          = ast_pkg::FIELD_W'(len);
    e.eq_len       = ast_pkg::FIELD_W'(eq);
    e.val_len      = ast_pkg::FIELD_W'(val);
    e.quote_kind   = qk;
    e.quote_closed = qc;
    return e;
  endfunction

  mode_e      mode_q, mode_d;
  pos_t       pos_q, pos_d;
  pos_t       dbeg_q, dbeg_d;
  logic       dpend_q, dpend_d;
  pos_t       kbeg_q, kbeg_d;
  pos_t       klen_q, klen_d;
  logic       kok_q, kok_d;
  pos_t       gap_q, gap_d;
  pos_t       eqlen_q, eqlen_d;
  pos_t       vlen_q, vlen_d;
  logic [1:0] oq_q, oq_d;
  logic       ovf_q, ovf_d;

  ast_pkg::bundle_t bnd;
  logic             accept;

  assign byte_i.ready = !full_i;
  assign accept       = byte_i.valid && byte_i.ready;
  assign push_o       = accept && (bnd.count != '0);
  assign bundle_o     = bnd;

  always_comb begin
    logic [7:0]                c;
    logic                      last;
    logic                      again;
    pos_t                      pos;
    pos_t                      end_pos;
    logic [ast_pkg::CNT_W-1:0] n;

    c       = byte_i.text_byte;
    last    = byte_i.final_byte;
    again   = 1'b0;
    n       = '0;
    bnd     = '0;
    mode_d  = mode_q;
    dbeg_d  = dbeg_q;
    dpend_d = dpend_q;
    kbeg_d  = kbeg_q;
    klen_d  = klen_q;
    kok_d   = kok_q;
    gap_d   = gap_q;
    eqlen_d = eqlen_q;
    vlen_d  = vlen_q;
    oq_d    = oq_q;
    ovf_d   = ovf_q;
    pos     = pos_q;
    if (pos_q == POS_MAX) begin
      ovf_d = 1'b1;
    end

    case (mode_q)
      MODE_KEY: begin
        if (is_delim(c)) begin
          if (!kok_q) begin
            if (!dpend_d) begin
              dpend_d = 1'b1;
              dbeg_d  = kbeg_d;
            end
            mode_d = MODE_BETWEEN;
            again  = 1'b1;
          end else if (is_ws(c)) begin
            gap_d  = POS_ONE;
            mode_d = MODE_GAP;
          end else if (c == CH_EQ) begin
            eqlen_d = POS_ONE;
            mode_d  = MODE_EQWS;
          end else begin
            if (dpend_d) begin
              bnd.ev[n[ast_pkg::EV_IDX_W-1:0]] = mk_ev(ast_pkg::EV_DIRTY, dbeg_d,
                sat_sub(kbeg_d, dbeg_d), POS_ZERO, POS_ZERO, QUOTE_NONE, 1'b0);
              n       = n + 1'b1;
              dpend_d = 1'b0;
            end
            bnd.ev[n[ast_pkg::EV_IDX_W-1:0]] = mk_ev(ast_pkg::EV_ATTR, kbeg_d, klen_d,
              POS_ZERO, POS_ZERO, QUOTE_NONE, 1'b0);
            n      = n + 1'b1;
            mode_d = MODE_BETWEEN;
            again  = 1'b1;
          end
        end else begin
          klen_d = sat_inc(klen_d);
          if (!rest_ok(c)) begin
            kok_d = 1'b0;
          end
        end
      end
      MODE_GAP: begin
        if (is_ws(c)) begin
          gap_d = sat_inc(gap_d);
        end else if (c == CH_EQ) begin
          eqlen_d = sat_inc(gap_d);
          mode_d  = MODE_EQWS;
        end else begin
          if (dpend_d) begin
            bnd.ev[n[ast_pkg::EV_IDX_W-1:0]] = mk_ev(ast_pkg::EV_DIRTY, dbeg_d,
              sat_sub(kbeg_d, dbeg_d), POS_ZERO, POS_ZERO, QUOTE_NONE, 1'b0);
            n = n + 1'b1;
          end
          bnd.ev[n[ast_pkg::EV_IDX_W-1:0]] = mk_ev(ast_pkg::EV_ATTR, kbeg_d, klen_d,
            POS_ZERO, POS_ZERO, QUOTE_NONE, 1'b0);
          n       = n + 1'b1;
          dpend_d = 1'b1;
          dbeg_d  = sat_add(kbeg_d, klen_d);
          mode_d  = MODE_BETWEEN;
          again   = 1'b1;
        end
      end
      MODE_EQWS: begin
        if (is_ws(c)) begin
          eqlen_d = sat_inc(eqlen_d);
        end else if (c == CH_DQ || c == CH_SQ) begin
          oq_d   = (c == CH_DQ) ? QUOTE_DOUBLE : QUOTE_SINGLE;
          vlen_d = POS_ZERO;
          mode_d = MODE_VALQ;
        end else begin
          vlen_d = POS_ONE;
          mode_d = MODE_VALU;
        end
      end
      MODE_VALU: begin
        if (is_ws(c)) begin
          if (dpend_d) begin
            bnd.ev[n[ast_pkg::EV_IDX_W-1:0]] = mk_ev(ast_pkg::EV_DIRTY, dbeg_d,
              sat_sub(kbeg_d, dbeg_d), POS_ZERO, POS_ZERO, QUOTE_NONE, 1'b0);
            n       = n + 1'b1;
            dpend_d = 1'b0;
          end
          bnd.ev[n[ast_pkg::EV_IDX_W-1:0]] = mk_ev(ast_pkg::EV_ATTR, kbeg_d, klen_d,
            eqlen_d, vlen_d, QUOTE_NONE, 1'b0);
          n      = n + 1'b1;
          mode_d = MODE_BETWEEN;
          again  = 1'b1;
        end else begin
          vlen_d = sat_inc(vlen_d);
        end
      end
      MODE_VALQ: begin
        if (c == ((oq_d == QUOTE_DOUBLE) ? CH_DQ : CH_SQ)) begin
          if (dpend_d) begin
            bnd.ev[n[ast_pkg::EV_IDX_W-1:0]] = mk_ev(ast_pkg::EV_DIRTY, dbeg_d,
              sat_sub(kbeg_d, dbeg_d), POS_ZERO, POS_ZERO, QUOTE_NONE, 1'b0);
            n       = n + 1'b1;
            dpend_d = 1'b0;
          end
          bnd.ev[n[ast_pkg::EV_IDX_W-1:0]] = mk_ev(ast_pkg::EV_ATTR, kbeg_d, klen_d,
            eqlen_d, vlen_d, oq_d, 1'b1);
          n      = n + 1'b1;
          mode_d = MODE_BETWEEN;
        end else begin
          vlen_d = sat_inc(vlen_d);
        end
      end
      default: begin
        mode_d = MODE_BETWEEN;
        if (is_delim(c)) begin
          if (!dpend_d) begin
            dpend_d = 1'b1;
            dbeg_d  = pos;
          end
        end else begin
          kbeg_d = pos;
          klen_d = POS_ONE;
          kok_d  = first_ok(c);
          mode_d = MODE_KEY;
        end
      end
    endcase

    if (again) begin
      if (is_delim(c)) begin
        if (!dpend_d) begin
          dpend_d = 1'b1;
          dbeg_d  = pos;
        end
      end else begin
        kbeg_d = pos;
        klen_d = POS_ONE;
        kok_d  = first_ok(c);
        mode_d = MODE_KEY;
      end
    end

    end_pos = sat_inc(pos);
    pos_d   = end_pos;

    if (last) begin
      case (mode_d)
        MODE_KEY, MODE_GAP, MODE_EQWS, MODE_VALU, MODE_VALQ: begin
          if (mode_d == MODE_KEY && !kok_d) begin
            if (!dpend_d) begin
              dpend_d = 1'b1;
              dbeg_d  = kbeg_d;
            end
          end else begin
            if (dpend_d) begin
              bnd.ev[n[ast_pkg::EV_IDX_W-1:0]] = mk_ev(ast_pkg::EV_DIRTY, dbeg_d,
                sat_sub(kbeg_d, dbeg_d), POS_ZERO, POS_ZERO, QUOTE_NONE, 1'b0);
              n       = n + 1'b1;
              dpend_d = 1'b0;
            end
            case (mode_d)
              MODE_EQWS: bnd.ev[n[ast_pkg::EV_IDX_W-1:0]] = mk_ev(ast_pkg::EV_ATTR, kbeg_d,
                klen_d, eqlen_d, POS_ZERO, QUOTE_NONE, 1'b0);
              MODE_VALU: bnd.ev[n[ast_pkg::EV_IDX_W-1:0]] = mk_ev(ast_pkg::EV_ATTR, kbeg_d,
                klen_d, eqlen_d, vlen_d, QUOTE_NONE, 1'b0);
              MODE_VALQ: bnd.ev[n[ast_pkg::EV_IDX_W-1:0]] = mk_ev(ast_pkg::EV_ATTR, kbeg_d,
                klen_d, eqlen_d, vlen_d, oq_d, 1'b0);
              default:   bnd.ev[n[ast_pkg::EV_IDX_W-1:0]] = mk_ev(ast_pkg::EV_ATTR, kbeg_d,
                klen_d, POS_ZERO, POS_ZERO, QUOTE_NONE, 1'b0);
            endcase
            n = n + 1'b1;
            if (mode_d == MODE_GAP) begin
              dpend_d = 1'b1;
              dbeg_d  = sat_add(kbeg_d, klen_d);
            end
          end
        end
        default: ;
      endcase
      if (dpend_d) begin
        bnd.ev[n[ast_pkg::EV_IDX_W-1:0]] = mk_ev(ast_pkg::EV_DIRTY, dbeg_d,
          sat_sub(end_pos, dbeg_d), POS_ZERO, POS_ZERO, QUOTE_NONE, 1'b0);
        n = n + 1'b1;
      end
    end

    bnd.count = n;
    bnd.ovf   = ovf_d;
    bnd.eor   = last;

    if (last) begin
      mode_d  = MODE_BETWEEN;
      pos_d   = POS_ZERO;
      dbeg_d  = POS_ZERO;
      dpend_d = 1'b0;
      kbeg_d  = POS_ZERO;
      klen_d  = POS_ZERO;
      kok_d   = 1'b0;
      gap_d   = POS_ZERO;
      eqlen_d = POS_ZERO;
      vlen_d  = POS_ZERO;
      oq_d    = QUOTE_NONE;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_BETWEEN;
      pos_q   <= POS_ZERO;
      dbeg_q  <= POS_ZERO;
      dpend_q <= 1'b0;
      kbeg_q  <= POS_ZERO;
      klen_q  <= POS_ZERO;
      kok_q   <= 1'b0;
      gap_q   <= POS_ZERO;
      eqlen_q <= POS_ZERO;
      vlen_q  <= POS_ZERO;
      oq_q    <= QUOTE_NONE;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      dbeg_q  <= dbeg_d;
      dpend_q <= dpend_d;
      kbeg_q  <= kbeg_d;
      klen_q  <= klen_d;
      kok_q   <= kok_d;
      gap_q   <= gap_d;
      eqlen_q <= eqlen_d;
      vlen_q  <= vlen_d;
      oq_q    <= oq_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

### hdl/ast_queue.sv
// ----------------------------------------------------------------------------
// ast_queue
// Short first-in first-out queue of event bundles between front and back.
// ----------------------------------------------------------------------------
module ast_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ast_pkg::bundle_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output ast_pkg::bundle_t head_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(ast_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(ast_pkg::QUEUE_DEPTH + 1);

  ast_pkg::bundle_t   store_q [ast_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d;
  logic [PTR_W-1:0]   rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (cnt_q == CNT_W'(ast_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = store_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### hdl/ast_back.sv
// ----------------------------------------------------------------------------
// ast_back
// Unpacks event bundles; presents one item per cycle while ready is high.
// ----------------------------------------------------------------------------
module ast_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ast_pkg::bundle_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  ast_event_if.source      event_o
);

  logic [ast_pkg::EV_IDX_W-1:0] idx_q, idx_d;
  logic                         valid_q;
  ast_pkg::event_t              ev_q;
  logic                         ovf_q;
  logic                         eor_q;
  logic                         load;
  logic                         last_ev;

  assign load    = !empty_i && (!valid_q || event_o.ready);
  assign last_ev = (ast_pkg::CNT_W'(idx_q) + 1'b1) == head_i.count;
  assign pop_o   = load && last_ev;
  assign idx_d   = last_ev ? '0 : idx_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= idx_d;
      end else if (event_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ev_q  <= head_i.ev[idx_q];
      ovf_q <= head_i.ovf;
      eor_q <= head_i.eor && last_ev;
    end
  end

  assign event_o.valid           = valid_q;
  assign event_o.event_kind      = ev_q.kind;
  assign event_o.span_start      = ev_q.start;
  assign event_o.span_len        = ev_q.len;
  assign event_o.eq_run_len      = ev_q.eq_len;
  assign event_o.value_len       = ev_q.val_len;
  assign event_o.quote_kind      = ev_q.quote_kind;
  assign event_o.quote_closed    = ev_q.quote_closed;
  assign event_o.length_overflow = ovf_q;
  assign event_o.end_of_record   = eor_q;

endmodule

### test/tb_attribute_span_tokenizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_attribute_span_tokenizer
// Feeds attribute records one byte per item and checks every event item
// against a span predictor kept in the bench (single byte records against
// the table): a directed table first (single byte records, key, gap, equals
// and quoted states, unclosed quotes, stray equals, bad keys), then random
// records that are mostly well formed, some cut short, some pure noise.
// ----------------------------------------------------------------------------
module tb_attribute_span_tokenizer;

  localparam int unsigned POS_WIDTH = ast_pkg::POS_WIDTH;
  localparam int unsigned FIELD_W   = ast_pkg::FIELD_W;
  localparam logic        EV_DIRTY  = ast_pkg::EV_DIRTY;
  localparam logic        EV_ATTR   = ast_pkg::EV_ATTR;

  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned RANDOM_ITEMS = 280;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef logic [POS_WIDTH-1:0] pos_t;
  localparam pos_t POS_MAX = '1;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_US    = 8'h5f;

  typedef enum logic [2:0] {
    SCAN_BETWEEN, SCAN_KEY, SCAN_GAP, SCAN_EQUALS, SCAN_BARE, SCAN_QUOTED
  } scan_e;
  typedef enum logic [1:0] {QUOTE_NONE, QUOTE_DOUBLE, QUOTE_SINGLE} quote_e;
  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_THROTTLED} sink_mode_e;

  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] eq_len;
    logic [FIELD_W-1:0] val_len;
    logic [1:0]         quote_kind;
    logic               quote_closed;
    logic               overflow;
    logic               last;
  } span_event_t;

  typedef struct packed {
    logic [7:0]  text;
    logic        fin;
    logic        pin;
    span_event_t want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 27;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{CH_SLASH, 1'b1, 1'b1,
      '{EV_DIRTY, 16'd0, 16'd1, 16'd0, 16'd0, QUOTE_NONE, 1'b0, 1'b0, 1'b1}},
    '{8'h00, 1'b1, 1'b1,
      '{EV_DIRTY, 16'd0, 16'd1, 16'd0, 16'd0, QUOTE_NONE, 1'b0, 1'b0, 1'b1}},
    '{8'hff, 1'b1, 1'b1,
      '{EV_DIRTY, 16'd0, 16'd1, 16'd0, 16'd0, QUOTE_NONE, 1'b0, 1'b0, 1'b1}},
    '{"a", 1'b1, 1'b1,
      '{EV_ATTR, 16'd0, 16'd1, 16'd0, 16'd0, QUOTE_NONE, 1'b0, 1'b0, 1'b1}},
    '{"A",      1'b0, 1'b0, '0},
    '{CH_CR,    1'b0, 1'b0, '0},
    '{CH_EQ,    1'b0, 1'b0, '0},
    '{CH_TAB,   1'b0, 1'b0, '0},
    '{CH_DQ,    1'b0, 1'b0, '0},
    '{"x",      1'b0, 1'b0, '0},
    '{CH_DQ,    1'b0, 1'b0, '0},
    '{CH_SLASH, 1'b0, 1'b0, '0},
    '{"b",      1'b1, 1'b0, '0},
    '{"1",      1'b0, 1'b0, '0},
    '{CH_DASH,  1'b0, 1'b0, '0},
    '{CH_VT,    1'b0, 1'b0, '0},
    '{"k",      1'b0, 1'b0, '0},
    '{CH_FF,    1'b0, 1'b0, '0},
    '{"c",      1'b1, 1'b0, '0},
    '{"v",      1'b0, 1'b0, '0},
    '{CH_EQ,    1'b0, 1'b0, '0},
    '{CH_SQ,    1'b0, 1'b0, '0},
    '{"z",      1'b1, 1'b0, '0},
    '{CH_EQ,    1'b0, 1'b0, '0},
    '{CH_LF,    1'b0, 1'b0, '0},
    '{"u",      1'b0, 1'b0, '0},
    '{CH_EQ,    1'b1, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ast_byte_if  byte_if ();
  ast_event_if event_if ();

  attribute_span_tokenizer u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_if),
    .event_o (event_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  scan_e       scan_state;
  quote_e      quote_held;
  pos_t        pos_cnt, dirty_from, key_from, key_len, ws_len, eq_acc, value_acc;
  logic        dirty_open, key_valid, sat_flag;
  span_event_t byte_spans[$];
  span_event_t expected_spans[$];
  logic [7:0]  record_bytes[$];
  int          err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int          burst_left = 0;
  sink_mode_e  sink_mode = SINK_OPEN;
  int          sink_left = 0;
  int          sink_phase = 0;

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF || c == CH_VT;
  endfunction

  function automatic bit is_separator(logic [7:0] c);
    return c == CH_SLASH || c == CH_EQ || is_space(c);
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit key_head_ok(logic [7:0] c);
    return is_letter(c) || c == CH_US || c == CH_COLON;
  endfunction

  function automatic bit key_tail_ok(logic [7:0] c);
    return is_letter(c) || (c >= "0" && c <= "9") || c == CH_COLON || c == CH_DOT ||
           c == CH_US || c == CH_DASH;
  endfunction

  function automatic pos_t sat_inc(pos_t x);
    return (x == POS_MAX) ? x : x + 1'b1;
  endfunction

  function automatic pos_t sat_add(pos_t a, pos_t b);
    logic [POS_WIDTH:0] s;
    s = a + b;
    return s[POS_WIDTH] ? POS_MAX : s[POS_WIDTH-1:0];
  endfunction

  function automatic pos_t sat_sub(pos_t a, pos_t b);
    return (a >= b) ? a - b : '0;
  endfunction

  function automatic void clear_scan();
    scan_state = SCAN_BETWEEN;
    quote_held = QUOTE_NONE;
    pos_cnt    = '0;
    dirty_from = '0;
    key_from   = '0;
    key_len    = '0;
    ws_len     = '0;
    eq_acc     = '0;
    value_acc  = '0;
    dirty_open = 1'b0;
    key_valid  = 1'b0;
    sat_flag   = 1'b0;
  endfunction

  function automatic void push_span(logic kind, pos_t start, pos_t len, pos_t eq, pos_t val,
                                    quote_e qk, logic qc);
    span_event_t e;
    e.kind         = kind;
    e.start        = start;
    e.len          = len;
    e.eq_len       = eq;
    e.val_len      = val;
    e.quote_kind   = qk;
    e.quote_closed = qc;
    e.overflow     = sat_flag;
    e.last         = 1'b0;
    byte_spans.push_back(e);
  endfunction

  function automatic void mark_dirty(pos_t from);
    if (!dirty_open) begin
      dirty_open = 1'b1;
      dirty_from = from;
    end
  endfunction

  function automatic void close_dirty(pos_t upto);
    if (dirty_open) begin
      push_span(EV_DIRTY, dirty_from, sat_sub(upto, dirty_from), '0, '0, QUOTE_NONE, 1'b0);
      dirty_open = 1'b0;
    end
  endfunction

  function automatic void push_attribute(pos_t eq, pos_t val, quote_e qk, logic qc);
    close_dirty(key_from);
    push_span(EV_ATTR, key_from, key_len, eq, val, qk, qc);
  endfunction

  function automatic void predict_spans(logic [7:0] c, logic fin);
    pos_t        at;
    pos_t        upto;
    bit          again;
    span_event_t tail_ev;
    byte_spans.delete();
    at = pos_cnt;
    if (at == POS_MAX) sat_flag = 1'b1;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (scan_state)
        SCAN_KEY: begin
          if (is_separator(c)) begin
            if (!key_valid) begin
              mark_dirty(key_from);
              scan_state = SCAN_BETWEEN;
              again = 1'b1;
            end else if (is_space(c)) begin
              ws_len = pos_t'(1);
              scan_state = SCAN_GAP;
            end else if (c == CH_EQ) begin
              eq_acc = pos_t'(1);
              scan_state = SCAN_EQUALS;
            end else begin
              push_attribute('0, '0, QUOTE_NONE, 1'b0);
              scan_state = SCAN_BETWEEN;
              again = 1'b1;
            end
          end else begin
            key_len = sat_inc(key_len);
            if (!key_tail_ok(c)) key_valid = 1'b0;
          end
        end
        SCAN_GAP: begin
          if (is_space(c)) begin
            ws_len = sat_inc(ws_len);
          end else if (c == CH_EQ) begin
            eq_acc = sat_inc(ws_len);
            scan_state = SCAN_EQUALS;
          end else begin
            push_attribute('0, '0, QUOTE_NONE, 1'b0);
            mark_dirty(sat_add(key_from, key_len));
            scan_state = SCAN_BETWEEN;
            again = 1'b1;
          end
        end
        SCAN_EQUALS: begin
          if (is_space(c)) begin
            eq_acc = sat_inc(eq_acc);
          end else if (c == CH_DQ || c == CH_SQ) begin
            quote_held = (c == CH_DQ) ? QUOTE_DOUBLE : QUOTE_SINGLE;
            value_acc = '0;
            scan_state = SCAN_QUOTED;
          end else begin
            value_acc = pos_t'(1);
            scan_state = SCAN_BARE;
          end
        end
        SCAN_BARE: begin
          if (is_space(c)) begin
            push_attribute(eq_acc, value_acc, QUOTE_NONE, 1'b0);
            scan_state = SCAN_BETWEEN;
            again = 1'b1;
          end else begin
            value_acc = sat_inc(value_acc);
          end
        end
        SCAN_QUOTED: begin
          if (c == ((quote_held == QUOTE_DOUBLE) ? CH_DQ : CH_SQ)) begin
            push_attribute(eq_acc, value_acc, quote_held, 1'b1);
            scan_state = SCAN_BETWEEN;
          end else begin
            value_acc = sat_inc(value_acc);
          end
        end
        default: begin
          scan_state = SCAN_BETWEEN;
          if (is_separator(c)) begin
            mark_dirty(at);
          end else begin
            key_from   = at;
            key_len    = pos_t'(1);
            key_valid  = key_head_ok(c);
            scan_state = SCAN_KEY;
          end
        end
      endcase
    end
    pos_cnt = sat_inc(at);
    if (fin) begin
      upto = sat_inc(at);
      case (scan_state)
        SCAN_KEY: begin
          if (key_valid) begin
            push_attribute('0, '0, QUOTE_NONE, 1'b0);
          end else begin
            mark_dirty(key_from);
            close_dirty(upto);
          end
        end
        SCAN_GAP: begin
          push_attribute('0, '0, QUOTE_NONE, 1'b0);
          mark_dirty(sat_add(key_from, key_len));
          close_dirty(upto);
        end
        SCAN_EQUALS: push_attribute(eq_acc, '0, QUOTE_NONE, 1'b0);
        SCAN_BARE:   push_attribute(eq_acc, value_acc, QUOTE_NONE, 1'b0);
        SCAN_QUOTED: push_attribute(eq_acc, value_acc, quote_held, 1'b0);
        default:     close_dirty(upto);
      endcase
      if (byte_spans.size() > 0) begin
        tail_ev = byte_spans.pop_back();
        tail_ev.last = 1'b1;
        byte_spans.push_back(tail_ev);
      end
      clear_scan();
    end
  endfunction

  function automatic void queue_spans();
    foreach (byte_spans[i]) expected_spans.push_back(byte_spans[i]);
  endfunction

  function automatic logic [7:0] random_space();
    case ($urandom_range(0, 5))
      0:       return CH_SP;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_CR;
      4:       return CH_FF;
      default: return CH_VT;
    endcase
  endfunction

  function automatic logic [7:0] random_head();
    int unsigned r;
    r = $urandom_range(0, 53);
    if (r < 26) return 8'("A" + r);
    if (r < 52) return 8'("a" + r - 26);
    return (r == 52) ? CH_US : CH_COLON;
  endfunction

  function automatic logic [7:0] random_tail();
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(0, 69);
    if (r < 52) return random_head();
    if (r < 62) return 8'("0" + r - 52);
    case (r)
      62: return CH_COLON;
      63: return CH_DOT;
      64: return CH_US;
      65: return CH_DASH;
      default: begin
        c = 8'($urandom_range(0, 255));
        return is_separator(c) ? "#" : c;
      end
    endcase
  endfunction

  task automatic build_record();
    int          n;
    int          form;
    logic [7:0]  c;
    logic [7:0]  q;
    record_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) record_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(0, 2))
          record_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_SLASH : random_space());
        if ($urandom_range(0, 9) == 0) record_bytes.push_back(CH_EQ);
        if ($urandom_range(0, 7) == 0) begin
          c = 8'($urandom_range(0, 255));
          record_bytes.push_back(is_separator(c) ? "9" : c);
        end else begin
          record_bytes.push_back(random_head());
        end
        repeat ($urandom_range(0, 5)) record_bytes.push_back(random_tail());
        form = $urandom_range(0, 4);
        if (form == 1) begin
          repeat ($urandom_range(1, 3)) record_bytes.push_back(random_space());
        end else if (form >= 2) begin
          repeat ($urandom_range(0, 2)) record_bytes.push_back(random_space());
          record_bytes.push_back(CH_EQ);
          repeat ($urandom_range(0, 2)) record_bytes.push_back(random_space());
          if (form == 2) begin
            repeat ($urandom_range(1, 5)) begin
              c = 8'($urandom_range(0, 255));
              record_bytes.push_back(is_space(c) ? "v" : c);
            end
          end else begin
            q = (form == 3) ? CH_DQ : CH_SQ;
            record_bytes.push_back(q);
            repeat ($urandom_range(0, 5)) begin
              c = 8'($urandom_range(0, 255));
              record_bytes.push_back((c == q) ? "q" : c);
            end
            record_bytes.push_back(q);
          end
        end
        record_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_SLASH : random_space());
      end
    end
    // cut short so records also end inside keys, gaps and values
    if ($urandom_range(0, 2) == 0) begin
      n = $urandom_range(1, record_bytes.size());
      while (record_bytes.size() > n) void'(record_bytes.pop_back());
    end
  endtask

  task automatic send_byte(logic [7:0] c, logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      if (gap > 0) begin
        byte_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    byte_if.valid      <= 1'b1;
    byte_if.text_byte  <= c;
    byte_if.final_byte <= fin;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    predict_spans(c, fin);
  endtask

  task automatic send_record();
    foreach (record_bytes[i]) begin
      send_byte(record_bytes[i], i == record_bytes.size() - 1);
      queue_spans();
    end
  endtask

  task automatic wait_idle();
    byte_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_spans.size() != 0);
    burst_left = 0;
  endtask

  function automatic void check_field(string name, logic [FIELD_W-1:0] want,
                                      logic [FIELD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : sink_pattern
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 2));
      sink_left = $urandom_range(16, 160);
    end else begin
      sink_left--;
    end
    sink_phase = (sink_phase + 1) % 3;
    case (sink_mode)
      SINK_OPEN:   event_if.ready <= 1'b1;
      SINK_RANDOM: event_if.ready <= 1'($urandom_range(0, 1));
      default:     event_if.ready <= (sink_phase == 0);
    endcase
  end

  always @(posedge clk_i) begin : span_check
    span_event_t want;
    if (rst_ni && event_if.valid && event_if.ready) begin
      if (expected_spans.size() == 0) begin
        $error("unexpected event item: kind %0d start %0d len %0d", event_if.event_kind,
               event_if.span_start, event_if.span_len);
        err_cnt++;
      end else begin
        want = expected_spans.pop_front();
        check_field("event_kind", FIELD_W'(want.kind), FIELD_W'(event_if.event_kind));
        check_field("span_start", want.start, event_if.span_start);
        check_field("span_len", want.len, event_if.span_len);
        check_field("eq_run_len", want.eq_len, event_if.eq_run_len);
        check_field("value_len", want.val_len, event_if.value_len);
        check_field("quote_kind", FIELD_W'(want.quote_kind), FIELD_W'(event_if.quote_kind));
        check_field("quote_closed", FIELD_W'(want.quote_closed),
                    FIELD_W'(event_if.quote_closed));
        check_field("length_overflow", FIELD_W'(want.overflow),
                    FIELD_W'(event_if.length_overflow));
        check_field("end_of_record", FIELD_W'(want.last), FIELD_W'(event_if.end_of_record));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_attribute_span_tokenizer: done, errors");
      $finish;
    end
  end

  initial begin
    int sent;
    bit paused;
    rst_ni             = 1'b0;
    byte_if.valid      = 1'b0;
    byte_if.text_byte  = 8'h00;
    byte_if.final_byte = 1'b0;
    clear_scan();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_byte(DIRECTED[i].text, DIRECTED[i].fin);
      if (DIRECTED[i].pin) expected_spans.push_back(DIRECTED[i].want);
      else queue_spans();
    end
    wait_idle();

    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      build_record();
      send_record();
      sent += record_bytes.size();
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_idle();
        paused = 1'b1;
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_attribute_span_tokenizer: done, clean");
    end else begin
      $display("tb_attribute_span_tokenizer: done, errors");
    end
    $finish;
  end

endmodule
